### rtl/core/rtid_pkg.sv
// ----------------------------------------------------------------------------
// rtid_pkg: shared types and constants of the run-length token image decoder
// Holds the palette geometry, the stream layout, the token and register codes,
// and the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package rtid_pkg;

  // Palette geometry.
  localparam int PALETTE_BANKS = 8;
  localparam int BANK_ENTRIES  = 256;
  localparam int STORE_DEPTH   = PALETTE_BANKS * BANK_ENTRIES;
  localparam int STORE_AW      = $clog2(STORE_DEPTH);

  // Stream widths.
  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 72;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Input beat selector carried in tuser bit 0.
  localparam logic OP_STREAM    = 1'b0;
  localparam logic OP_PAL_WRITE = 1'b1;

  // Token kinds in the top three bits of a token byte.
  localparam logic [2:0] KIND_LITERAL     = 3'd0;
  localparam logic [2:0] KIND_TRANSPARENT = 3'd1;
  localparam logic [2:0] KIND_REPEAT      = 3'd2;
  localparam logic [2:0] KIND_NEWLINE     = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_BANK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y     = 2'd3;

  // Decode phase of the stream parser.
  typedef enum logic [2:0] {
    PH_TOKEN     = 3'd0,
    PH_LIT_FIRST = 3'd1,
    PH_LIT_HIGH  = 3'd2,
    PH_REP_FIRST = 3'd3,
    PH_REP_HIGH  = 3'd4
  } phase_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } ctrl_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic in_ready;   // the input channel can take a beat
    logic accept;     // take the input beat
    logic emit_step;  // load one result into the output register
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic start_emit; // the offered beat produces results
    logic out_free;   // output register can take a result this cycle
    logic last_beat;  // the pending result is the final one of its byte
  } dp_stat_t;

endpackage

### rtl/core/rtid_ctrl.sv
// ----------------------------------------------------------------------------
// rtid_ctrl: controller of the run-length token image decoder
// Takes input beats while idle and steps the datapath through the results
// that one byte produces, one per free output slot.
// ----------------------------------------------------------------------------
module rtid_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  rtid_pkg::dp_stat_t  stat,
  output rtid_pkg::ctrl_cmd_t cmd
);
  import rtid_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && stat.start_emit) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free && stat.last_beat) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd.in_ready  = 1'b0;
    cmd.accept    = 1'b0;
    cmd.emit_step = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.accept   = s_tvalid;
      end
      ST_EMIT: cmd.emit_step = stat.out_free;
      default: ;
    endcase
  end

endmodule

### rtl/core/rtid_dp.sv
// ----------------------------------------------------------------------------
// rtid_dp: datapath of the run-length token image decoder
// Holds the configuration registers, the parser state, the palette memory,
// the run emitter and the output register.
// ----------------------------------------------------------------------------
module rtid_dp (
  input  logic                            clk,
  input  logic                            rst,
  // input stream payload
  input  logic                            s_tvalid,
  input  logic [rtid_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic [rtid_pkg::S_TUSER_W-1:0]  s_tuser,
  // output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rtid_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic                            m_tuser,
  output logic                            m_tlast,
  // configuration writes
  input  logic                            cfg_valid,
  input  logic [rtid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtid_pkg::CFG_DATA_W-1:0] cfg_data,
  // controller link
  input  rtid_pkg::ctrl_cmd_t             cmd,
  output rtid_pkg::dp_stat_t              stat
);
  import rtid_pkg::*;

  // Input fields.
  logic        in_opcode;
  logic        in_fstart;
  logic [7:0]  in_byte;
  logic [10:0] in_pal_addr;
  logic [15:0] in_pal_value;

  assign in_opcode    = s_tuser[0];
  assign in_fstart    = s_tuser[1];
  assign in_byte      = s_tdata[7:0];
  assign in_pal_addr  = s_tdata[18:8];
  assign in_pal_value = s_tdata[34:19];

  // Configuration.
  logic        palette_mode;
  logic [2:0]  palette_bank;
  logic [15:0] offset_x;
  logic [15:0] offset_y;

  // Parser state.
  logic [15:0] column_count;
  logic [15:0] row_count;
  phase_t      phase;
  logic [5:0]  run_remaining;
  logic [7:0]  low_byte_hold;
  logic        halted;

  // Emitter state.
  logic [5:0]  emit_left;
  logic [14:0] emit_colour;
  logic        emit_opaque;
  logic        emit_err;
  logic        emit_pal;
  logic        pal_oob;

  // Palette memory.
  logic [15:0] pal_mem [STORE_DEPTH];
  logic [15:0] pal_rd_data;
  logic [STORE_AW-1:0] pal_wr_addr;
  logic [STORE_AW-1:0] pal_rd_addr;
  logic        pal_wr_en;

  // Output register.
  logic [16:0] o_x;
  logic [16:0] o_y;
  logic [7:0]  o_red;
  logic [7:0]  o_green;
  logic [7:0]  o_blue;
  logic [7:0]  o_alpha;
  logic        o_err;
  logic        o_last;

  // Decode results.
  logic [15:0] eff_col;
  logic [15:0] eff_row;
  phase_t      eff_phase;
  logic [5:0]  eff_run;
  logic [7:0]  eff_low;
  logic        eff_halt;
  logic [15:0] col_next;
  logic [15:0] row_next;
  phase_t      phase_next;
  logic [5:0]  run_next;
  logic [7:0]  low_next;
  logic        halt_next;
  logic        dec_emit;
  logic [5:0]  dec_count;
  logic [14:0] dec_colour;
  logic        dec_opaque;
  logic        dec_err;
  logic        dec_pal;
  logic        dec_repeat;
  logic [5:0]  tok_len;
  logic [2:0]  tok_kind;
  logic [14:0] pix_colour;

  // Configuration register writes; the port never stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      palette_mode <= 1'b0;
      palette_bank <= 3'd0;
      offset_x     <= 16'd0;
      offset_y     <= 16'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PALETTE_MODE: palette_mode <= cfg_data[0];
        CFG_PALETTE_BANK: palette_bank <= cfg_data[2:0];
        CFG_OFFSET_X:     offset_x     <= cfg_data;
        CFG_OFFSET_Y:     offset_y     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Palette addresses; entries past the store are dropped or read as black.
  assign pal_wr_addr = STORE_AW'(in_pal_addr);
  assign pal_rd_addr = STORE_AW'({palette_bank, in_byte});
  assign pal_wr_en   = cmd.accept && (in_opcode == OP_PAL_WRITE) &&
                       (32'(in_pal_addr) < STORE_DEPTH);

  always_ff @(posedge clk) begin
    if (pal_wr_en) begin
      pal_mem[pal_wr_addr] <= in_pal_value;
    end
    if (cmd.accept) begin
      pal_rd_data <= pal_mem[pal_rd_addr];
    end
  end

  // State as seen by this byte, after a frame start clears it.
  always_comb begin
    eff_col   = in_fstart ? 16'd0 : column_count;
    eff_row   = in_fstart ? 16'd0 : row_count;
    eff_phase = in_fstart ? PH_TOKEN : phase;
    eff_run   = in_fstart ? 6'd0 : run_remaining;
    eff_low   = in_fstart ? 8'd0 : low_byte_hold;
    eff_halt  = in_fstart ? 1'b0 : halted;
  end

  assign tok_len  = {1'b0, in_byte[4:0]} + 6'd1;
  assign tok_kind = in_byte[7:5];
  assign dec_repeat = (eff_phase == PH_REP_FIRST) || (eff_phase == PH_REP_HIGH);

  // Byte decode: next parser state and the run to emit.
  always_comb begin
    col_next   = eff_col;
    row_next   = eff_row;
    phase_next = eff_phase;
    run_next   = eff_run;
    low_next   = eff_low;
    halt_next  = eff_halt;
    dec_emit   = 1'b0;
    dec_count  = 6'd0;
    dec_colour = {in_byte[6:0], eff_low};
    dec_opaque = 1'b1;
    dec_err    = 1'b0;
    dec_pal    = 1'b0;
    if (in_opcode == OP_STREAM && !eff_halt) begin
      unique case (eff_phase)
        PH_TOKEN: begin
          unique case (tok_kind)
            KIND_LITERAL: begin
              run_next   = tok_len;
              phase_next = PH_LIT_FIRST;
            end
            KIND_REPEAT: begin
              run_next   = tok_len;
              phase_next = PH_REP_FIRST;
            end
            KIND_TRANSPARENT: begin
              dec_emit   = 1'b1;
              dec_count  = tok_len;
              dec_colour = 15'd0;
              dec_opaque = 1'b0;
            end
            KIND_NEWLINE: begin
              row_next = (eff_row == 16'hFFFF) ? eff_row : eff_row + 16'd1;
              col_next = 16'd0;
            end
            default: begin
              dec_emit  = 1'b1;
              dec_count = 6'd1;
              dec_err   = 1'b1;
              halt_next = 1'b1;
              run_next  = 6'd0;
            end
          endcase
        end
        PH_LIT_FIRST, PH_REP_FIRST, PH_LIT_HIGH, PH_REP_HIGH: begin
          if ((eff_phase == PH_LIT_FIRST || eff_phase == PH_REP_FIRST) &&
              !palette_mode) begin
            // Low byte of a direct colour: hold it for the high byte.
            low_next   = in_byte;
            phase_next = dec_repeat ? PH_REP_HIGH : PH_LIT_HIGH;
          end else begin
            // A colour is complete: one literal pixel or the whole repeat run.
            dec_pal   = (eff_phase == PH_LIT_FIRST || eff_phase == PH_REP_FIRST);
            dec_count = dec_repeat ? eff_run : 6'd1;
            dec_emit  = (dec_count != 6'd0);
            if (dec_repeat) begin
              run_next   = 6'd0;
              phase_next = PH_TOKEN;
            end else begin
              run_next   = (eff_run != 6'd0) ? eff_run - 6'd1 : 6'd0;
              phase_next = (run_next == 6'd0) ? PH_TOKEN : PH_LIT_FIRST;
            end
          end
        end
        default: phase_next = PH_TOKEN;
      endcase
    end
  end

  // Parser state and emitter load on an accepted beat; column steps per pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= 16'd0;
      row_count     <= 16'd0;
      phase         <= PH_TOKEN;
      run_remaining <= 6'd0;
      low_byte_hold <= 8'd0;
      halted        <= 1'b0;
    end else if (cmd.accept && in_opcode == OP_STREAM) begin
      column_count  <= col_next;
      row_count     <= row_next;
      phase         <= phase_next;
      run_remaining <= run_next;
      low_byte_hold <= low_next;
      halted        <= halt_next;
    end else if (cmd.emit_step && !emit_err && column_count != 16'hFFFF) begin
      column_count <= column_count + 16'd1;
    end
  end

  // Emitter run registers.
  always_ff @(posedge clk) begin
    if (cmd.accept && dec_emit) begin
      emit_left   <= dec_count;
      emit_colour <= dec_colour;
      emit_opaque <= dec_opaque;
      emit_err    <= dec_err;
      emit_pal    <= dec_pal;
      pal_oob     <= !(32'(palette_bank) < PALETTE_BANKS);
    end else if (cmd.emit_step) begin
      emit_left <= emit_left - 6'd1;
    end
  end

  // Colour of the pending pixel.
  always_comb begin
    if (!emit_pal) begin
      pix_colour = emit_colour;
    end else if (pal_oob) begin
      pix_colour = 15'd0;
    end else begin
      pix_colour = pal_rd_data[14:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      o_err  <= emit_err;
      o_last <= stat.last_beat;
      if (emit_err) begin
        o_x     <= 17'd0;
        o_y     <= 17'd0;
        o_red   <= 8'd0;
        o_green <= 8'd0;
        o_blue  <= 8'd0;
        o_alpha <= 8'd0;
      end else begin
        o_x     <= {1'b0, column_count} + {1'b0, offset_x};
        o_y     <= {1'b0, row_count} + {1'b0, offset_y};
        o_red   <= {pix_colour[14:10], 3'b000};
        o_green <= {pix_colour[9:5], 3'b000};
        o_blue  <= {pix_colour[4:0], 3'b000};
        o_alpha <= emit_opaque ? 8'hFF : 8'h00;
      end
    end
  end

  assign m_tdata = {6'd0, o_alpha, o_blue, o_green, o_red, o_y, o_x};
  assign m_tuser = o_err;
  assign m_tlast = o_last;

  // Status to the controller.
  assign stat.start_emit = s_tvalid && dec_emit;
  assign stat.out_free   = !m_tvalid || m_tready;
  assign stat.last_beat  = emit_err || (emit_left == 6'd1);

endmodule

### rtl/core/rle_token_image_decoder.sv
// ----------------------------------------------------------------------------
// rle_token_image_decoder: run-length token image decoder, RGB555 pixels
// Decodes a byte stream of run tokens into pixel writes with coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one beat per stream byte or palette write; tuser
//   bit 0 selects a palette write, bit 1 marks a frame start. The m_ channel
//   carries one pixel per beat; tlast marks the last pixel of a byte and tuser
//   flags an unknown token. The cfg_ channel writes the four registers and is
//   always ready; write it only while the block is idle.
//   A byte that yields no pixel is done in its accept cycle. A byte that
//   yields N pixels is accepted, then the run emitter loads the output
//   register with one pixel per cycle while that register is free. Each pixel
//   passes from the emitter run registers into the output register. Palette
//   reads come from a registered memory port, read in the accept cycle.
//   While the receiver stalls, the emitter waits and s_tready stays low until
//   the run is out; a finished pixel waiting in the output register does not
//   block the next byte. Reset clears the registers, the decode position and
//   the output valid; the palette memory is undefined until written.
// ----------------------------------------------------------------------------
module rle_token_image_decoder (
  input  logic                            clk,
  input  logic                            rst,
  // data_byte[7:0], pal_address[18:8], pal_value[34:19], zero fill
  input  logic [rtid_pkg::S_TDATA_W-1:0]  s_tdata,
  // opcode[0], frame_start[1]
  input  logic [rtid_pkg::S_TUSER_W-1:0]  s_tuser,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // out_x[16:0], out_y[33:17], red[41:34], green[49:42], blue[57:50],
  // alpha[65:58], zero fill
  output logic [rtid_pkg::M_TDATA_W-1:0]  m_tdata,
  // token_error[0]
  output logic                            m_tuser,
  output logic                            m_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rtid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtid_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rtid_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // The input is ready whenever the controller is idle.
  assign s_tready  = cmd.in_ready;
  assign cfg_ready = 1'b1;

  rtid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .stat     (stat),
    .cmd      (cmd)
  );

  rtid_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

### rtl/core/rtid_checker.sv
// ----------------------------------------------------------------------------
// rtid_checker: port-level checks of the run-length token image decoder
// Watches the output stream for reset, stall and error-beat behavior.
// ----------------------------------------------------------------------------
module rtid_checker (
  input logic                            clk,
  input logic                            rst,
  input logic [rtid_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic                            m_tuser,
  input logic                            m_tlast,
  input logic                            m_tvalid,
  input logic                            m_tready
);
  import rtid_pkg::*;

  // A stalled beat keeps its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // An error beat is the only result of its byte.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("error beat without last");

  // An error beat carries no pixel.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("error beat with pixel data");

endmodule

bind rle_token_image_decoder rtid_checker u_rtid_checker (.*);
